### hw/rtl/lattice_random_walk_stepper_assert.svh
// Assertion macros used by the checker of the walk stepper.
`ifndef LATTICE_RANDOM_WALK_STEPPER_ASSERT_SVH
`define LATTICE_RANDOM_WALK_STEPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRWS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("walk stepper check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRWS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("walk stepper check failed");

`endif

### hw/rtl/lrws_pkg.sv
package lrws_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_GRID_SIDE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_LIFETIME = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WEIGHT_UP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WEIGHT_DOWN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_WEIGHT_LEFT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WEIGHT_RIGHT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RNG_SEED     = 3'd6;

   localparam logic [15:0] GRID_SIDE_RESET    = 16'd256;
   localparam logic [23:0] MAX_LIFETIME_RESET = 24'd1000;
   localparam logic [8:0]  WEIGHT_RESET       = 9'd64;
   localparam logic [31:0] RNG_SEED_RESET     = 32'd1;

   localparam logic [2:0] OUT_STAY  = 3'd0;
   localparam logic [2:0] OUT_DONE  = 3'd1;
   localparam logic [2:0] OUT_RIGHT = 3'd2;
   localparam logic [2:0] OUT_LEFT  = 3'd3;
   localparam logic [2:0] OUT_UP    = 3'd4;
   localparam logic [2:0] OUT_DOWN  = 3'd5;

   localparam int PROD_W = 25;

   // Draw order of the generator: up, down, left, right.
   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DRAW,
      ST_SETTLE,
      ST_MOVE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        load;
      logic [31:0] seed;
      logic        advance;
   } rng_ctl_type;

   typedef struct packed {
      logic    mul_en;
      dir_type dir;
   } pick_ctl_type;

endpackage

### hw/rtl/lrws_req_if.sv
interface lrws_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [23:0] age;

   modport source (output valid, output pos_x, output pos_y, output age, input ready);
   modport sink (input valid, input pos_x, input pos_y, input age, output ready);
endinterface

### hw/rtl/lrws_rsp_if.sv
interface lrws_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] new_x;
   logic [15:0] new_y;
   logic [23:0] new_age;
   logic [2:0]  outcome;

   modport source (
      output valid, output new_x, output new_y, output new_age, output outcome,
      input ready
   );
   modport sink (
      input valid, input new_x, input new_y, input new_age, input outcome,
      output ready
   );
endinterface

### hw/rtl/lrws_rng.sv
module lrws_rng (
   input  logic                clock,
   input  logic                reset,
   input  lrws_pkg::rng_ctl_type ctl,
   output logic [15:0]         draw
);

   logic [31:0] state_ff;
   logic [31:0] state_in;
   logic [31:0] s1;
   logic [31:0] s2;
   logic [31:0] step_val;

   // Xorshift32 with shifts 13, 17 and 5.
   always_comb begin
      s1       = state_ff ^ (state_ff << 13);
      s2       = s1 ^ (s1 >> 17);
      step_val = s2 ^ (s2 << 5);
   end

   // The draw is taken from the state that this advance produces.
   assign draw = step_val[31:16];

   always_comb begin
      state_in = state_ff;
      if (ctl.load) begin
         // A zero seed would lock the generator, so it is loaded as one.
         state_in = (ctl.seed == 32'd0) ? 32'd1 : ctl.seed;
      end else if (ctl.advance) begin
         state_in = step_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrws_pkg::RNG_SEED_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/lrws_pick.sv
module lrws_pick (
   input  logic                   clock,
   input  logic                   reset,
   input  lrws_pkg::pick_ctl_type ctl,
   input  logic [8:0]             weight,
   input  logic [15:0]            draw,
   output lrws_pkg::dir_type      best_dir
);

   logic [lrws_pkg::PROD_W-1:0] prod_ff;
   lrws_pkg::dir_type           tag_ff;
   logic                        pend_ff;
   logic [lrws_pkg::PROD_W-1:0] best_ff;
   lrws_pkg::dir_type           best_dir_ff;
   logic                        take;

   // Ties go to up, then down, then right, then left. Draws arrive in the
   // order up, down, left, right, so only right may win a tie, and only
   // against left.
   always_comb begin
      take = (tag_ff == lrws_pkg::DIR_UP) || (prod_ff > best_ff) ||
             ((tag_ff == lrws_pkg::DIR_RIGHT) && (prod_ff == best_ff) &&
              (best_dir_ff == lrws_pkg::DIR_LEFT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         best_dir_ff <= lrws_pkg::DIR_UP;
      end else begin
         pend_ff <= ctl.mul_en;
         if (pend_ff && take) begin
            best_dir_ff <= tag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= {16'd0, weight} * {9'd0, draw};
         tag_ff  <= ctl.dir;
      end
      if (pend_ff && take) begin
         best_ff <= prod_ff;
      end
   end

   assign best_dir = best_dir_ff;

endmodule

### hw/rtl/lattice_random_walk_stepper.sv
// Channel    Role     Carries
// req_chan   sink     pos_x, pos_y, age of one walker
// rsp_chan   source   new_x, new_y, new_age, outcome
// csr_*      write    csr_we, csr_index, csr_wdata (no read-back)
//
// A request passes the idle state, then for each step a lifetime check, four draws
// through the shared generator and multiplier, a compare and a move, and at last a
// finish state that loads the result once the output register is free.
// Reset is synchronous and clears the configuration, the sequencer and the generator.
// A new request is taken while the previous result still waits; the result
// of that request is held back until the output register is free.
module lattice_random_walk_stepper #(
   parameter int STEPS_PER_VISIT = 50
) (
   input  logic                                clock,
   input  logic                                reset,
   lrws_req_if.sink                            req_chan,
   lrws_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [lrws_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lrws_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int STEP_W = $clog2(STEPS_PER_VISIT + 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_PER_VISIT - 1);

   logic [15:0] grid_side_ff;
   logic [23:0] max_lifetime_ff;
   logic [8:0]  weight_up_ff;
   logic [8:0]  weight_down_ff;
   logic [8:0]  weight_left_ff;
   logic [8:0]  weight_right_ff;

   lrws_pkg::state_type state_ff, state_in;
   lrws_pkg::dir_type   draw_ff, draw_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [15:0]         x_ff, x_in;
   logic [15:0]         y_ff, y_in;
   logic [23:0]         age_ff, age_in;
   logic [2:0]          outcome_ff, outcome_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_x_ff;
   logic [15:0]         rsp_y_ff;
   logic [23:0]         rsp_age_ff;
   logic [2:0]          rsp_outcome_ff;
   logic                rsp_load;

   lrws_pkg::rng_ctl_type  rng_ctl;
   lrws_pkg::pick_ctl_type pick_ctl;
   logic [15:0]            draw;
   logic [8:0]             weight;
   lrws_pkg::dir_type      best_dir;

   logic signed [17:0] xs;
   logic signed [17:0] ys;
   logic signed [17:0] side_s;
   logic [15:0]        far_edge;

   lrws_rng u_rng (
      .clock (clock),
      .reset (reset),
      .ctl   (rng_ctl),
      .draw  (draw)
   );

   lrws_pick u_pick (
      .clock    (clock),
      .reset    (reset),
      .ctl      (pick_ctl),
      .weight   (weight),
      .draw     (draw),
      .best_dir (best_dir)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff    <= lrws_pkg::GRID_SIDE_RESET;
         max_lifetime_ff <= lrws_pkg::MAX_LIFETIME_RESET;
         weight_up_ff    <= lrws_pkg::WEIGHT_RESET;
         weight_down_ff  <= lrws_pkg::WEIGHT_RESET;
         weight_left_ff  <= lrws_pkg::WEIGHT_RESET;
         weight_right_ff <= lrws_pkg::WEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lrws_pkg::REG_GRID_SIDE:    grid_side_ff    <= csr_wdata[15:0];
            lrws_pkg::REG_MAX_LIFETIME: max_lifetime_ff <= csr_wdata[23:0];
            lrws_pkg::REG_WEIGHT_UP:    weight_up_ff    <= csr_wdata[8:0];
            lrws_pkg::REG_WEIGHT_DOWN:  weight_down_ff  <= csr_wdata[8:0];
            lrws_pkg::REG_WEIGHT_LEFT:  weight_left_ff  <= csr_wdata[8:0];
            lrws_pkg::REG_WEIGHT_RIGHT: weight_right_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (draw_ff)
         lrws_pkg::DIR_UP:    weight = weight_up_ff;
         lrws_pkg::DIR_DOWN:  weight = weight_down_ff;
         lrws_pkg::DIR_LEFT:  weight = weight_left_ff;
         lrws_pkg::DIR_RIGHT: weight = weight_right_ff;
      endcase
   end

   // Candidate position of the move, wide enough for -1 and 65536.
   always_comb begin
      xs = $signed({2'b00, x_ff});
      ys = $signed({2'b00, y_ff});
      unique case (best_dir)
         lrws_pkg::DIR_UP:    ys = ys + 18'sd1;
         lrws_pkg::DIR_DOWN:  ys = ys - 18'sd1;
         lrws_pkg::DIR_LEFT:  xs = xs - 18'sd1;
         lrws_pkg::DIR_RIGHT: xs = xs + 18'sd1;
      endcase
      side_s   = $signed({2'b00, grid_side_ff});
      far_edge = grid_side_ff - 16'd1;
   end

   assign req_chan.ready = (state_ff == lrws_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      draw_in      = draw_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      age_in       = age_ff;
      outcome_in   = outcome_ff;
      rsp_load     = 1'b0;
      rng_ctl.load    = csr_we && (csr_index == lrws_pkg::REG_RNG_SEED);
      rng_ctl.seed    = csr_wdata;
      rng_ctl.advance = 1'b0;
      pick_ctl.mul_en = 1'b0;
      pick_ctl.dir    = draw_ff;

      unique case (state_ff)
         lrws_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               x_in       = req_chan.pos_x;
               y_in       = req_chan.pos_y;
               age_in     = req_chan.age;
               step_in    = '0;
               outcome_in = lrws_pkg::OUT_STAY;
               state_in   = lrws_pkg::ST_CHECK;
            end
         end
         lrws_pkg::ST_CHECK: begin
            if (age_ff == max_lifetime_ff) begin
               outcome_in = lrws_pkg::OUT_DONE;
               state_in   = lrws_pkg::ST_FINISH;
            end else begin
               age_in   = age_ff + 24'd1;
               draw_in  = lrws_pkg::DIR_UP;
               state_in = lrws_pkg::ST_DRAW;
            end
         end
         lrws_pkg::ST_DRAW: begin
            rng_ctl.advance = 1'b1;
            pick_ctl.mul_en = 1'b1;
            draw_in = lrws_pkg::dir_type'(2'(draw_ff) + 2'd1);
            if (draw_ff == lrws_pkg::DIR_RIGHT) begin
               state_in = lrws_pkg::ST_SETTLE;
            end
         end
         lrws_pkg::ST_SETTLE: begin
            // The last product is compared during this cycle.
            state_in = lrws_pkg::ST_MOVE;
         end
         lrws_pkg::ST_MOVE: begin
            priority if (xs >= side_s) begin
               x_in       = 16'd0;
               y_in       = ys[15:0];
               outcome_in = lrws_pkg::OUT_RIGHT;
               state_in   = lrws_pkg::ST_FINISH;
            end else if (xs < 18'sd0) begin
               x_in       = far_edge;
               y_in       = ys[15:0];
               outcome_in = lrws_pkg::OUT_LEFT;
               state_in   = lrws_pkg::ST_FINISH;
            end else if (ys >= side_s) begin
               x_in       = xs[15:0];
               y_in       = 16'd0;
               outcome_in = lrws_pkg::OUT_UP;
               state_in   = lrws_pkg::ST_FINISH;
            end else if (ys < 18'sd0) begin
               x_in       = xs[15:0];
               y_in       = far_edge;
               outcome_in = lrws_pkg::OUT_DOWN;
               state_in   = lrws_pkg::ST_FINISH;
            end else begin
               x_in = xs[15:0];
               y_in = ys[15:0];
               if (step_ff == LAST_STEP) begin
                  state_in = lrws_pkg::ST_FINISH;
               end else begin
                  step_in  = step_ff + STEP_W'(1);
                  state_in = lrws_pkg::ST_CHECK;
               end
            end
         end
         lrws_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = lrws_pkg::ST_IDLE;
            end
         end
         default: state_in = lrws_pkg::ST_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrws_pkg::ST_IDLE;
         draw_ff      <= lrws_pkg::DIR_UP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         draw_ff      <= draw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      age_ff     <= age_in;
      outcome_ff <= outcome_in;
      if (rsp_load) begin
         rsp_x_ff       <= x_ff;
         rsp_y_ff       <= y_ff;
         rsp_age_ff     <= age_ff;
         rsp_outcome_ff <= outcome_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.new_x   = rsp_x_ff;
   assign rsp_chan.new_y   = rsp_y_ff;
   assign rsp_chan.new_age = rsp_age_ff;
   assign rsp_chan.outcome = rsp_outcome_ff;

endmodule

### hw/rtl/lrws_checker.sv
`include "lattice_random_walk_stepper_assert.svh"

module lrws_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_new_x,
   input logic [15:0] rsp_new_y,
   input logic [2:0]  rsp_outcome
);

   logic        stalled;
   logic        wrap_ok;
   logic [34:0] rsp_word;

   assign stalled  = rsp_valid && !rsp_ready;
   assign rsp_word = {rsp_new_x, rsp_new_y, rsp_outcome};

   // Crossing the right or top edge wraps the coordinate to zero.
   assign wrap_ok = !((rsp_outcome == lrws_pkg::OUT_RIGHT && rsp_new_x != 16'd0) ||
                      (rsp_outcome == lrws_pkg::OUT_UP && rsp_new_y != 16'd0));

   // A walker occupies the sequencer after it is taken, so the request channel drops ready.
   `LRWS_ASSERT_NEXT(a_busy_after_request, clock, reset, req_valid && req_ready, !req_ready)

   `LRWS_ASSERT_SAME(a_outcome_code, clock, reset, rsp_valid, rsp_outcome <= lrws_pkg::OUT_DOWN)

   `LRWS_ASSERT_SAME(a_wrap_zero, clock, reset, rsp_valid, wrap_ok)

   `LRWS_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_word))

endmodule

bind lattice_random_walk_stepper lrws_checker u_lrws_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_new_x   (rsp_chan.new_x),
   .rsp_new_y   (rsp_chan.new_y),
   .rsp_outcome (rsp_chan.outcome)
);
